>>> rtl/pfba_pkg.sv
// Shared types and constants for the page frame bitmap allocator.
package pfba_pkg;

  localparam int FRAME_W     = 20;
  localparam int WORD_W      = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] OP_ALLOC      = 3'd0;
  localparam logic [2:0] OP_ALLOC_USER = 3'd1;
  localparam logic [2:0] OP_FREE       = 3'd2;
  localparam logic [2:0] OP_MARK_USED  = 3'd3;
  localparam logic [2:0] OP_MARK_FREE  = 3'd4;

  localparam logic [2:0] CMD_NOP        = 3'd0;
  localparam logic [2:0] CMD_ALLOC      = 3'd1;
  localparam logic [2:0] CMD_ALLOC_USER = 3'd2;
  localparam logic [2:0] CMD_FREE       = 3'd3;
  localparam logic [2:0] CMD_MARK_USED  = 3'd4;
  localparam logic [2:0] CMD_MARK_FREE  = 3'd5;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] address;
    logic [31:0] length;
  } pfba_req_t;

  typedef struct packed {
    logic [25:0] page_address;
    logic        granted;
    logic [14:0] free_count;
  } pfba_rsp_t;

  // Classified command: frames first..last inclusive.
  typedef struct packed {
    logic [2:0]         kind;
    logic [FRAME_W-1:0] first;
    logic [FRAME_W-1:0] last;
  } pfba_cmd_t;

endpackage

>>> rtl/page_frame_bitmap_allocator.sv
// Top level of the page frame bitmap allocator.
// After reset the block sweeps both bitmaps, one 32-bit word per cycle, over
// ceil(NUM_FRAMES/32) words (512 at the defaults) with busy high; every frame
// then reads as used and no frame as user. Each item gives exactly one result,
// in order, on result for one cycle marked by done; the receiver cannot stall
// it. The back end reads one bitmap word per cycle from RAM, so the number of
// words walked sets the time. An alloc walks words up to and including the
// first word with a free frame, a free reads the one word of its frame, a
// range mark walks every word it covers, and an ignored item gives its result
// with no walk. A two-entry queue lets the front end take further items while
// the back end walks the bitmap; busy rises when the queue is full and the
// front end holds an item.
module page_frame_bitmap_allocator #(
  parameter int NUM_FRAMES = 16384,
  parameter int PAGE_SHIFT = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  pfba_pkg::pfba_req_t request,
  output logic                done,
  output pfba_pkg::pfba_rsp_t result
);

  logic                clearing;
  logic                q_full;
  logic                q_empty;
  logic                push;
  logic                pop;
  pfba_pkg::pfba_cmd_t push_cmd;
  pfba_pkg::pfba_cmd_t head;

  pfba_front #(.NUM_FRAMES(NUM_FRAMES), .PAGE_SHIFT(PAGE_SHIFT)) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .request  (request),
    .clearing (clearing),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  pfba_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  pfba_back #(.NUM_FRAMES(NUM_FRAMES), .PAGE_SHIFT(PAGE_SHIFT)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .head     (head),
    .pop      (pop),
    .clearing (clearing),
    .done     (done),
    .result   (result)
  );

endmodule

>>> rtl/pfba_ram.sv
// Generic simple dual-port RAM with registered read.
module pfba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/pfba_queue.sv
// Two-entry command queue between the front end and the back end.
module pfba_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  pfba_pkg::pfba_cmd_t push_cmd,
  input  logic                pop,
  output pfba_pkg::pfba_cmd_t head,
  output logic                full,
  output logic                empty
);

  localparam int DEPTH = pfba_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);

  pfba_pkg::pfba_cmd_t entries [DEPTH];
  logic [PW-1:0]       wr_ptr;
  logic [PW-1:0]       rd_ptr;
  logic [CNTW-1:0]     count;

  assign full  = (count == CNTW'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CNTW'(1);
      end else if (pop && !push) begin
        count <= count - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

>>> rtl/pfba_front.sv
// Front end: takes requests, checks and clamps them, queues frame-range commands.
module pfba_front #(
  parameter int NUM_FRAMES = 16384,
  parameter int PAGE_SHIFT = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  pfba_pkg::pfba_req_t request,
  input  logic                clearing,
  input  logic                q_full,
  output logic                push,
  output pfba_pkg::pfba_cmd_t push_cmd
);

  localparam int FRW = pfba_pkg::FRAME_W;
  localparam int FW = $clog2(NUM_FRAMES);
  localparam int SW = (FW + PAGE_SHIFT + 1 > 34) ? FW + PAGE_SHIFT + 1 : 34;
  localparam logic [SW-1:0] LIMIT = SW'(NUM_FRAMES) << PAGE_SHIFT;
  localparam logic [FRW-1:0] LAST_FRAME = FRW'(NUM_FRAMES - 1);

  pfba_pkg::pfba_req_t item;
  logic                front_valid;
  logic                accept;
  logic [SW-1:0]       addr_w;
  logic [SW-1:0]       start_frame;
  logic [SW-1:0]       sum_m1;
  logic                mark_ok;

  assign busy   = clearing || (front_valid && q_full);
  assign accept = start && !busy;
  assign push   = front_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (accept) begin
      front_valid <= 1'b1;
    end else if (push) begin
      front_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= request;
    end
  end

  always_comb begin
    addr_w      = SW'(item.address);
    start_frame = addr_w >> PAGE_SHIFT;
    sum_m1      = addr_w + SW'(item.length) - SW'(1);
    mark_ok     = (item.length != '0) && (addr_w < LIMIT);
    push_cmd.kind  = pfba_pkg::CMD_NOP;
    push_cmd.first = '0;
    push_cmd.last  = '0;
    case (item.op)
      pfba_pkg::OP_ALLOC: begin
        push_cmd.kind = pfba_pkg::CMD_ALLOC;
        push_cmd.last = LAST_FRAME;
      end
      pfba_pkg::OP_ALLOC_USER: begin
        push_cmd.kind = pfba_pkg::CMD_ALLOC_USER;
        push_cmd.last = LAST_FRAME;
      end
      pfba_pkg::OP_FREE: begin
        if ((item.address[PAGE_SHIFT-1:0] == '0) && (start_frame < SW'(NUM_FRAMES))) begin
          push_cmd.kind  = pfba_pkg::CMD_FREE;
          push_cmd.first = FRW'(start_frame);
          push_cmd.last  = FRW'(start_frame);
        end
      end
      pfba_pkg::OP_MARK_USED, pfba_pkg::OP_MARK_FREE: begin
        if (mark_ok) begin
          push_cmd.kind  = (item.op == pfba_pkg::OP_MARK_USED) ?
                           pfba_pkg::CMD_MARK_USED : pfba_pkg::CMD_MARK_FREE;
          push_cmd.first = FRW'(start_frame);
          push_cmd.last  = (sum_m1 >= LIMIT) ? LAST_FRAME :
                           FRW'(sum_m1 >> PAGE_SHIFT);
        end
      end
      default: begin
        push_cmd.kind = pfba_pkg::CMD_NOP;
      end
    endcase
  end

endmodule

>>> rtl/pfba_back.sv
// Back end: walks bitmap words in RAM, updates used/user bits and the free count.
module pfba_back #(
  parameter int NUM_FRAMES = 16384,
  parameter int PAGE_SHIFT = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  pfba_pkg::pfba_cmd_t head,
  output logic                pop,
  output logic                clearing,
  output logic                done,
  output pfba_pkg::pfba_rsp_t result
);

  localparam int WORD_W    = pfba_pkg::WORD_W;
  localparam int MAP_WORDS = (NUM_FRAMES + WORD_W - 1) / WORD_W;
  localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CW        = $clog2(NUM_FRAMES + 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  logic [1:0]          state;
  logic [WW-1:0]       clr_idx;
  pfba_pkg::pfba_cmd_t cur;
  logic [WW-1:0]       rd_ptr;
  logic                rd_more;
  logic                data_valid;
  logic [WW-1:0]       data_idx;
  logic [CW-1:0]       count;

  logic                rd_en;
  logic                wr_en;
  logic [WW-1:0]       wr_addr;
  logic [WORD_W-1:0]   used_rd;
  logic [WORD_W-1:0]   user_rd;
  logic [WORD_W-1:0]   used_wr;
  logic [WORD_W-1:0]   user_wr;

  logic                is_alloc;
  logic [WW-1:0]       first_w;
  logic [WW-1:0]       last_w;
  logic [4:0]          lo;
  logic [4:0]          hi;
  logic [WORD_W-1:0]   range_mask;
  logic                found;
  logic [4:0]          zb;
  logic [WW+4:0]       hit_frame;
  logic                hit;
  logic [WW+4+PAGE_SHIFT:0] page_wide;
  logic [WORD_W-1:0]   flips;
  logic [5:0]          pop_cnt;
  logic [WORD_W-1:0]   new_used;
  logic [WORD_W-1:0]   new_user;
  logic [CW-1:0]       count_next;
  logic                run_step;
  logic                finish;

  assign clearing = (state == ST_CLEAR);
  assign pop      = (state == ST_IDLE) && !q_empty;
  assign rd_en    = (state == ST_RUN) && rd_more;

  always_comb begin
    is_alloc   = (cur.kind == pfba_pkg::CMD_ALLOC) || (cur.kind == pfba_pkg::CMD_ALLOC_USER);
    first_w    = WW'(cur.first >> 5);
    last_w     = WW'(cur.last >> 5);
    lo         = (data_idx == first_w) ? cur.first[4:0] : 5'd0;
    hi         = (data_idx == last_w) ? cur.last[4:0] : 5'd31;
    range_mask = ({WORD_W{1'b1}} << lo) & ({WORD_W{1'b1}} >> (5'd31 - hi));
    found = 1'b0;
    zb    = 5'd0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!used_rd[b]) begin
        found = 1'b1;
        zb    = 5'(b);
      end
    end
    hit_frame = {data_idx, zb};
    hit       = found && ({1'b0, hit_frame} < (WW + 6)'(NUM_FRAMES));
    page_wide = {hit_frame, {PAGE_SHIFT{1'b0}}};
    run_step  = (state == ST_RUN) && data_valid;

    new_used = used_rd;
    new_user = user_rd;
    flips    = '0;
    case (cur.kind)
      pfba_pkg::CMD_ALLOC, pfba_pkg::CMD_ALLOC_USER: begin
        new_used = used_rd | (WORD_W'(1) << zb);
        if (cur.kind == pfba_pkg::CMD_ALLOC_USER) begin
          new_user = user_rd | (WORD_W'(1) << zb);
        end
      end
      pfba_pkg::CMD_MARK_USED: begin
        flips    = range_mask & ~used_rd;
        new_used = used_rd | range_mask;
      end
      pfba_pkg::CMD_FREE: begin
        flips    = range_mask & used_rd;
        new_used = used_rd & ~range_mask;
        new_user = user_rd & ~range_mask;
      end
      pfba_pkg::CMD_MARK_FREE: begin
        flips    = range_mask & used_rd;
        new_used = used_rd & ~range_mask;
      end
      default: begin
        flips = '0;
      end
    endcase
    pop_cnt = 6'($countones(flips));

    count_next = count;
    if (run_step) begin
      if (is_alloc) begin
        if (hit) begin
          count_next = count - CW'(1);
        end
      end else if (cur.kind == pfba_pkg::CMD_MARK_USED) begin
        count_next = count - CW'(pop_cnt);
      end else begin
        count_next = count + CW'(pop_cnt);
      end
    end

    finish = run_step && (is_alloc ? (found || data_idx == last_w) : (data_idx == last_w));

    wr_en   = clearing || (run_step && (!is_alloc || hit));
    wr_addr = clearing ? clr_idx : data_idx;
    used_wr = clearing ? {WORD_W{1'b1}} : new_used;
    user_wr = clearing ? '0 : new_user;
  end

  pfba_ram #(.WIDTH(WORD_W), .DEPTH(MAP_WORDS)) u_used_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (used_wr),
    .rd_en   (rd_en),
    .rd_addr (rd_ptr),
    .rd_data (used_rd)
  );

  pfba_ram #(.WIDTH(WORD_W), .DEPTH(MAP_WORDS)) u_user_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (user_wr),
    .rd_en   (rd_en),
    .rd_addr (rd_ptr),
    .rd_data (user_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_idx    <= '0;
      rd_more    <= 1'b0;
      data_valid <= 1'b0;
      count      <= '0;
      done       <= 1'b0;
    end else begin
      done  <= (pop && (head.kind == pfba_pkg::CMD_NOP)) || finish;
      count <= count_next;
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + WW'(1);
          if (clr_idx == WW'(MAP_WORDS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (!q_empty) begin
            if (head.kind == pfba_pkg::CMD_NOP) begin
              result.page_address <= '0;
              result.granted      <= 1'b0;
              result.free_count   <= 15'(count);
            end else begin
              state      <= ST_RUN;
              rd_ptr     <= WW'(head.first >> 5);
              rd_more    <= 1'b1;
              data_valid <= 1'b0;
            end
          end
        end
        ST_RUN: begin
          data_valid <= rd_en && !finish;
          data_idx   <= rd_ptr;
          if (rd_en) begin
            rd_ptr <= rd_ptr + WW'(1);
          end
          if (finish) begin
            state               <= ST_IDLE;
            rd_more             <= 1'b0;
            result.page_address <= (is_alloc && hit) ? 26'(page_wide) : '0;
            result.granted      <= is_alloc && hit;
            result.free_count   <= 15'(count_next);
          end else if (rd_en) begin
            rd_more <= (rd_ptr != last_w);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (pop) begin
        cur <= head;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(NUM_FRAMES))
    else $error("free count above frame total");

  a_no_rw_collide: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_ptr))
    else $error("bitmap read and write at one word");

  a_grant_alloc: assert property (@(posedge clk) disable iff (rst)
    (done && result.granted) |->
      (cur.kind == pfba_pkg::CMD_ALLOC || cur.kind == pfba_pkg::CMD_ALLOC_USER))
    else $error("grant on non-alloc item");

  a_data_in_run: assert property (@(posedge clk) disable iff (rst)
    data_valid |-> (state == ST_RUN))
    else $error("read data pending outside run");

endmodule
